[rtl/core/cip_pkg.sv]
package cip_pkg;

   // result kinds, carried on tuser
   localparam logic [1:0] KIND_PRG    = 2'd0;
   localparam logic [1:0] KIND_CHR    = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   // report status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BAD     = 3'd1;
   localparam logic [2:0] ST_NES2    = 3'd2;
   localparam logic [2:0] ST_NO_PRG  = 3'd3;
   localparam logic [2:0] ST_TOO_BIG = 3'd4;
   localparam logic [2:0] ST_MAPPER  = 3'd5;

   localparam int unsigned POS_W   = 20;
   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam int unsigned HDR_CNT = 5;
   localparam int unsigned DATA_W  = 80;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W   = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W   = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [1:0]        kind;
      logic [DATA_W-1:0] data;
   } rsp_item_type;

   // up to two results of one item, written in order
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } res_pair_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h4E;
         2'd1:    val = 8'h45;
         2'd2:    val = 8'h53;
         default: val = 8'h1A;
      endcase
      return val;
   endfunction

endpackage

[rtl/core/cip_parse.sv]
module cip_parse #(
   parameter int unsigned PRG_ROM_MAX  = 262144,
   parameter int unsigned CHR_ROM_MAX  = 8192,
   parameter int unsigned PRG_RAM_MAX  = 32768,
   parameter int unsigned CHR_RAM_SIZE = 8192
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            byte_value,
   input  logic                  final_byte,
   output cip_pkg::res_pair_type results
);
   import cip_pkg::*;

   localparam logic [22:0] PRG_LIM       = 23'(PRG_ROM_MAX);
   localparam logic [20:0] CHR_LIM       = 21'(CHR_ROM_MAX);
   localparam logic [7:0]  UNIT_LIM      = 8'(PRG_RAM_MAX / 8192);
   localparam logic [13:0] CHR_RAM_FIELD = 14'(CHR_RAM_SIZE);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       hdr_ff [HDR_CNT];
   logic             magic_ff, magic_in;
   logic [2:0]       hstat_ff, hstat_in;

   logic [21:0] prg_total;
   logic [20:0] chr_raw, chr_total;
   logic [9:0]  trainer;
   logic [2:0]  judge;
   logic [POS_W-1:0] off, off2;
   logic        off_ge, in_prg, in_chr, write_ok;
   logic [21:0] chr_off;
   logic [17:0] wr_addr;

   logic [20:0] size, skip, avail;
   logic [21:0] prg_got, rest, chr_got;
   logic [7:0]  units, mapper;
   logic [2:0]  st_base, st_rep;
   logic [1:0]  mirr;
   logic        batt, chr_ram;
   logic [13:0] chr_field;
   rsp_item_type wr_item, rep_item;

   assign prg_total = {hdr_ff[0], 14'd0};
   assign chr_raw   = {hdr_ff[1], 13'd0};
   assign chr_total = (chr_raw > CHR_LIM) ? CHR_LIM : chr_raw;
   assign trainer   = hdr_ff[2][2] ? 10'd512 : 10'd0;

   // verdict uses the header as stored, the magic including this byte
   always_comb begin
      if (!magic_in) begin
         judge = ST_BAD;
      end else if ((hdr_ff[3] & 8'h0C) == 8'h08) begin
         judge = ST_NES2;
      end else if (prg_total == '0) begin
         judge = ST_NO_PRG;
      end else if ({1'b0, prg_total} > PRG_LIM) begin
         judge = ST_TOO_BIG;
      end else begin
         judge = ST_OK;
      end
   end

   // data write path
   assign off     = pos_ff - POS_W'(16);
   assign off_ge  = off >= POS_W'(trainer);
   assign off2    = off - POS_W'(trainer);
   assign in_prg  = {2'b00, off2} < prg_total;
   assign chr_off = {2'b00, off2} - prg_total;
   assign in_chr  = chr_off < {1'b0, chr_total};
   assign write_ok = (pos_ff >= POS_W'(16)) && (pos_ff != POS_MAX) && (hstat_ff == ST_OK)
                     && off_ge && (in_prg || in_chr);
   assign wr_addr = in_prg ? off2[17:0] : chr_off[17:0];

   always_comb begin
      wr_item      = '0;
      wr_item.kind = in_prg ? KIND_PRG : KIND_CHR;
      wr_item.data[17:0]  = wr_addr;
      wr_item.data[25:18] = byte_value;
   end

   // final report
   assign size    = {1'b0, pos_ff} + 21'd1;
   assign skip    = 21'd16 + 21'(trainer);
   assign avail   = (size > skip) ? size - skip : '0;
   assign prg_got = (prg_total < {1'b0, avail}) ? prg_total : {1'b0, avail};
   assign rest    = {1'b0, avail} - prg_got;
   assign chr_got = ({1'b0, chr_total} < rest) ? {1'b0, chr_total} : rest;
   assign mapper  = (hdr_ff[3] & 8'hF0) | (hdr_ff[2] >> 4);
   assign mirr    = hdr_ff[2][3] ? 2'd2 : (hdr_ff[2][0] ? 2'd1 : 2'd0);
   assign batt    = hdr_ff[2][1];
   assign chr_ram = (hdr_ff[1] == 8'd0);
   assign chr_field = chr_ram ? CHR_RAM_FIELD : chr_got[13:0];

   always_comb begin
      units = (hdr_ff[4] == 8'd0) ? 8'd1 : hdr_ff[4];
      if (units > UNIT_LIM) begin
         units = UNIT_LIM;
      end
   end

   always_comb begin
      if (pos_ff < POS_W'(15)) begin
         st_base = ST_BAD;
      end else if (pos_ff == POS_W'(15)) begin
         st_base = judge;
      end else begin
         st_base = hstat_ff;
      end
      st_rep = st_base;
      if (st_base == ST_OK && mapper != 8'd0 && mapper != 8'd2) begin
         st_rep = ST_MAPPER;
      end
   end

   always_comb begin
      rep_item      = '0;
      rep_item.kind = KIND_REPORT;
      rep_item.data[28:26] = st_rep;
      if (st_base != ST_BAD) begin
         rep_item.data[36:29] = mapper;
      end
      if (st_base == ST_OK) begin
         rep_item.data[38:37] = mirr;
         rep_item.data[39]    = batt;
         rep_item.data[40]    = chr_ram;
         rep_item.data[43:41] = units[2:0];
         rep_item.data[62:44] = prg_got[18:0];
         rep_item.data[76:63] = chr_field;
      end
   end

   always_comb begin
      results = '0;
      if (take) begin
         if (write_ok) begin
            results.first  = wr_item;
            results.second = rep_item;
            results.count  = final_byte ? 2'd2 : 2'd1;
         end else if (final_byte) begin
            results.first = rep_item;
            results.count = 2'd1;
         end
      end
   end

   // state update
   always_comb begin
      pos_in   = (pos_ff != POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
      magic_in = magic_ff;
      if (pos_ff < POS_W'(4) && byte_value != magic_byte(pos_ff[1:0])) begin
         magic_in = 1'b0;
      end
      hstat_in = (pos_ff == POS_W'(15)) ? judge : hstat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         magic_ff <= 1'b1;
         hstat_ff <= ST_OK;
         for (int i = 0; i < HDR_CNT; i++) begin
            hdr_ff[i] <= '0;
         end
      end else if (take) begin
         if (final_byte) begin
            pos_ff   <= '0;
            magic_ff <= 1'b1;
            hstat_ff <= ST_OK;
            for (int i = 0; i < HDR_CNT; i++) begin
               hdr_ff[i] <= '0;
            end
         end else begin
            pos_ff   <= pos_in;
            magic_ff <= magic_in;
            hstat_ff <= hstat_in;
            for (int i = 0; i < HDR_CNT; i++) begin
               if (pos_ff == POS_W'(4 + i)) begin
                  hdr_ff[i] <= byte_value;
               end
            end
         end
      end
   end

endmodule

[rtl/core/cip_rsp_fifo.sv]
module cip_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  cip_pkg::res_pair_type push,
   output logic                  space_ok,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cip_pkg::rsp_item_type out_item
);
   import cip_pkg::*;

   rsp_item_type     mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;

   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   // two free entries needed, an item may give two results
   assign space_ok  = (cnt_ff <= CNT_W'(FIFO_DEPTH - 2));

   always_comb begin
      wr_in  = wr_ff + PTR_W'(push.count);
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + PTR_W'(1)] <= push.second;
      end
   end

endmodule

[rtl/core/cartridge_image_parser.sv]
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata byte_value, tlast final_byte
// rsp     | out | rsp_tvalid/rsp_tready | tuser kind, tdata write and report fields
//
// one item per cycle while the queue has space: an input register, one pass of parse logic,
// then a four-entry result queue; the last byte may give two results
// an accepted item is held in the input register, then in the result queue, before rsp
// reset (synchronous, active high) clears the header state and empties the queue
// req_tready drops only while the queue holds more than two results
module cartridge_image_parser #(
   parameter int unsigned PRG_ROM_MAX  = 262144,
   parameter int unsigned CHR_ROM_MAX  = 8192,
   parameter int unsigned PRG_RAM_MAX  = 32768,
   parameter int unsigned CHR_RAM_SIZE = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [17:0] write_address, [25:18] write_data,
                                    // [28:26] status, [36:29] mapper_number,
                                    // [38:37] mirroring, [39] battery, [40] chr_is_ram,
                                    // [43:41] ram_units, [62:44] prg_bytes,
                                    // [76:63] chr_bytes, [79:77] zero
   output logic [1:0]  rsp_tuser    // [1:0] kind
);
   import cip_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       space_ok, advance;

   res_pair_type results;
   rsp_item_type out_item;

   assign advance     = in_valid_ff && space_ok;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // header tracking and write / report generation
   cip_parse #(
      .PRG_ROM_MAX  (PRG_ROM_MAX),
      .CHR_ROM_MAX  (CHR_ROM_MAX),
      .PRG_RAM_MAX  (PRG_RAM_MAX),
      .CHR_RAM_SIZE (CHR_RAM_SIZE)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .take       (advance),
      .byte_value (in_byte_ff),
      .final_byte (in_last_ff),
      .results    (results)
   );

   // result queue, decouples the sides
   cip_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (results),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = out_item.data;
   assign rsp_tuser = out_item.kind;

endmodule

[tb/cip_checker.sv]
`timescale 1ns / 1ps

// watches both channels of the parser, predicts every result and compares
module cip_checker #(
   parameter int unsigned PRG_ROM_MAX  = 262144,
   parameter int unsigned CHR_ROM_MAX  = 8192,
   parameter int unsigned PRG_RAM_MAX  = 32768,
   parameter int unsigned CHR_RAM_SIZE = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // final_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,   // [17:0] write_address .. [76:63] chr_bytes
   input  logic [1:0]  rsp_tuser,   // [1:0] kind
   output int          mismatches,
   output int          results_due_count
);
   import cip_pkg::*;

   // "NES" then 0x1A, first byte lowest
   localparam logic [31:0] MAGIC_WORD = 32'h1A53454E;

   logic [POS_W-1:0] byte_pos;
   logic [7:0]       hdr_field [HDR_CNT];
   logic             magic_ok;
   logic [2:0]       hdr_verdict;
   rsp_item_type     result_due [$];
   int               fail_total;

   task automatic clear_image();
      byte_pos    = '0;
      magic_ok    = 1'b1;
      hdr_verdict = ST_OK;
      for (int i = 0; i < HDR_CNT; i++) hdr_field[i] = 8'h00;
   endtask

   // advances the parser state by one byte and queues what it gives
   task automatic parse_byte(input logic [7:0] value, input logic last);
      int unsigned  pos, off, train, prg, chr, avail, prg_got, units, chr_got;
      logic [7:0]   f6, f7, mapper;
      logic [2:0]   st;
      rsp_item_type res;
      pos = byte_pos;
      if (pos < 4) begin
         if (value != MAGIC_WORD[pos*8 +: 8]) magic_ok = 1'b0;
      end else if (pos < 9) begin
         hdr_field[pos-4] = value;
      end
      train = hdr_field[2][2] ? 512 : 0;
      prg   = hdr_field[0] * 16384;
      chr   = hdr_field[1] * 8192;
      if (chr > CHR_ROM_MAX) chr = CHR_ROM_MAX;
      if (pos == 15) begin
         if (!magic_ok)                      hdr_verdict = ST_BAD;
         else if (hdr_field[3][3:2] == 2'b10) hdr_verdict = ST_NES2;
         else if (prg == 0)                  hdr_verdict = ST_NO_PRG;
         else if (prg > PRG_ROM_MAX)         hdr_verdict = ST_TOO_BIG;
         else                                hdr_verdict = ST_OK;
      end
      if (pos >= 16 && pos < POS_MAX && hdr_verdict == ST_OK && pos - 16 >= train) begin
         off = pos - 16 - train;
         res = '0;
         if (off < prg) begin
            res.kind         = KIND_PRG;
            res.data[17:0]   = 18'(off);
            res.data[25:18]  = value;
            result_due.push_back(res);
         end else if (off - prg < chr) begin
            res.kind         = KIND_CHR;
            res.data[17:0]   = 18'(off - prg);
            res.data[25:18]  = value;
            result_due.push_back(res);
         end
      end
      if (pos < POS_MAX) byte_pos = byte_pos + 1'b1;
      if (last) begin
         f6     = hdr_field[2];
         f7     = hdr_field[3];
         mapper = {f7[7:4], f6[7:4]};
         st     = (pos < 15) ? ST_BAD : hdr_verdict;
         res    = '0;
         res.kind = KIND_REPORT;
         if (st != ST_BAD) res.data[36:29] = mapper;
         if (st == ST_OK) begin
            avail   = (pos + 1 > 16 + train) ? pos + 1 - 16 - train : 0;
            prg_got = (prg < avail) ? prg : avail;
            units   = (hdr_field[4] != 0) ? hdr_field[4] : 1;
            if (units > PRG_RAM_MAX / 8192) units = PRG_RAM_MAX / 8192;
            res.data[38:37] = f6[3] ? 2'd2 : {1'b0, f6[0]};
            res.data[39]    = f6[1];
            if (hdr_field[1] == 0) begin
               res.data[40]    = 1'b1;
               res.data[76:63] = 14'(CHR_RAM_SIZE);
            end else begin
               chr_got = avail - prg_got;
               if (chr < chr_got) chr_got = chr;
               res.data[76:63] = 14'(chr_got);
            end
            res.data[43:41] = 3'(units);
            res.data[62:44] = 19'(prg_got);
            if (mapper != 8'd0 && mapper != 8'd2) st = ST_MAPPER;
         end
         res.data[28:26] = st;
         result_due.push_back(res);
         clear_image();
      end
   endtask

   always @(posedge clock) begin : watch
      logic [81:0] got, want;
      int          lo, w;
      string       label;
      bit          bad;
      int unsigned want_f, got_f;
      if (reset) begin
         clear_image();
         result_due.delete();
         fail_total = 0;
      end else begin
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (result_due.size() == 0) begin
               if (fail_total < 10)
                  $display("unexpected result kind %0d data %h", rsp_tuser, rsp_tdata);
               fail_total++;
            end else begin
               want = result_due.pop_front();
               bad  = 1'b0;
               for (int f = 0; f < 12; f++) begin
                  case (f)
                     0:  begin lo = 0;  w = 18; label = "write_address"; end
                     1:  begin lo = 18; w = 8;  label = "write_data";    end
                     2:  begin lo = 26; w = 3;  label = "status";        end
                     3:  begin lo = 29; w = 8;  label = "mapper_number"; end
                     4:  begin lo = 37; w = 2;  label = "mirroring";     end
                     5:  begin lo = 39; w = 1;  label = "battery";       end
                     6:  begin lo = 40; w = 1;  label = "chr_is_ram";    end
                     7:  begin lo = 41; w = 3;  label = "ram_units";     end
                     8:  begin lo = 44; w = 19; label = "prg_bytes";     end
                     9:  begin lo = 63; w = 14; label = "chr_bytes";     end
                     10: begin lo = 77; w = 3;  label = "padding";       end
                     default: begin lo = 80; w = 2; label = "kind"; end
                  endcase
                  want_f = 32'(want >> lo) & ((32'd1 << w) - 1);
                  got_f  = 32'(got >> lo) & ((32'd1 << w) - 1);
                  if (want_f != got_f) begin
                     bad = 1'b1;
                     if (fail_total < 10)
                        $display("mismatch on %s: expected %0d, got %0d", label, want_f, got_f);
                  end
               end
               if (bad) fail_total++;
            end
         end
      end
      mismatches        = fail_total;
      results_due_count = result_due.size();
   end

endmodule

[tb/tb_cartridge_image_parser.sv]
`timescale 1ns / 1ps

// drives cartridge images into the parser and gives the verdict
module tb_cartridge_image_parser;
   import cip_pkg::*;

   // random images stop once this many bytes have gone in
   localparam int unsigned RANDOM_BYTES = 1900;
   // cycles without any handshake before the run is abandoned
   localparam int unsigned STALL_LIMIT  = 4000;
   // receiver hold-off, long enough to back the block up to its input
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] byte_value
   logic        req_tlast  = 1'b0;    // final_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;            // [17:0] write_address, [25:18] write_data,
                                      // [28:26] status, [36:29] mapper_number,
                                      // [38:37] mirroring, [39] battery, [40] chr_is_ram,
                                      // [43:41] ram_units, [62:44] prg_bytes,
                                      // [76:63] chr_bytes, [79:77] zero
   logic [1:0]  rsp_tuser;            // [1:0] kind
   int          mismatch_count;
   int          results_waiting;

   // header of the image being sent
   logic [7:0]  img_hdr [16];
   // no gaps on the sender side for the current image
   bit          quiet;
   int unsigned stalled_cycles = 0;

   always #4 clock = ~clock;

   cartridge_image_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   cip_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .mismatches        (mismatch_count),
      .results_due_count (results_waiting)
   );

   // offers one item, after a random gap, and waits until it is taken
   task automatic send_byte(input logic [7:0] value, input logic last);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // header from img_hdr, random bytes after it, final flag on the last one
   task automatic send_image(input int unsigned len);
      quiet = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < len; i++)
         send_byte((i < 16) ? img_hdr[i] : 8'($urandom), i == len - 1);
   endtask

   task automatic set_magic();
      img_hdr[0] = 8'h4E;
      img_hdr[1] = 8'h45;
      img_hdr[2] = 8'h53;
      img_hdr[3] = 8'h1A;
   endtask

   // mostly sound headers with supported mappers, the rest broken in one way
   task automatic draw_header();
      int unsigned pick;
      set_magic();
      for (int i = 9; i < 16; i++) img_hdr[i] = 8'($urandom);
      // program units, now and then exactly at the limit
      img_hdr[4] = ($urandom_range(0, 7) == 0) ? 8'd16 : 8'($urandom_range(1, 3));
      // character units: ram, one, or more than the limit
      img_hdr[5] = 8'($urandom_range(0, 2));
      img_hdr[6] = 8'($urandom);
      img_hdr[6][2] = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 3)) inside
         0, 1:    img_hdr[6][7:4] = 4'd0;
         2:       img_hdr[6][7:4] = 4'd2;
         default: ;
      endcase
      img_hdr[7] = 8'($urandom);
      if (img_hdr[7][3:2] == 2'b10) img_hdr[7][3] = 1'b0;
      if ($urandom_range(0, 3) != 0) img_hdr[7][7:4] = 4'd0;
      img_hdr[8] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         // left sound
      end else if (pick < 65) begin
         // one flipped bit in the magic
         pick = $urandom_range(0, 3);
         img_hdr[pick] = img_hdr[pick] ^ (8'd1 << $urandom_range(0, 7));
      end else if (pick < 73) begin
         img_hdr[7][3:2] = 2'b10;
      end else if (pick < 81) begin
         img_hdr[4] = 8'd0;
      end else if (pick < 89) begin
         img_hdr[4] = 8'($urandom_range(17, 255));
      end else if (pick < 95) begin
         for (int i = 4; i < 9; i++) img_hdr[i] = 8'($urandom);
      end else begin
         for (int i = 0; i < 16; i++) img_hdr[i] = 8'($urandom);
      end
   endtask

   // receiver: random stalls, bursts with none, and two long hold-offs
   initial begin : rsp_side
      int unsigned taken;
      int unsigned wait_n;
      bit          fast;
      taken = 0;
      fast  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 64 == 0) fast = ($urandom_range(0, 3) == 0);
         if (taken == 40 || taken == 200)
            wait_n = HOLD_CYCLES;
         else
            wait_n = fast ? 0 : $urandom_range(0, 12);
         if (wait_n != 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned len;
      int unsigned pick;
      int unsigned sent;
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // a lone final byte at the top of the range: short image
      img_hdr[0] = 8'hFF;
      send_image(1);

      // sound magic but the image ends inside the header
      set_magic();
      img_hdr[4] = 8'h01;
      img_hdr[5] = 8'h00;
      img_hdr[6] = 8'h00;
      img_hdr[7] = 8'h00;
      send_image(8);

      // header only: trainer flagged, all flag bits set, unsupported mapper,
      // ram units over the limit, program size clamps to zero
      set_magic();
      img_hdr[4] = 8'h01;
      img_hdr[5] = 8'h00;
      img_hdr[6] = 8'hFF;
      img_hdr[7] = 8'h00;
      img_hdr[8] = 8'hFF;
      for (int i = 9; i < 16; i++) img_hdr[i] = 8'hFF;
      send_image(16);

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         draw_header();
         pick = $urandom_range(0, 99);
         if (pick < 8)
            len = $urandom_range(1, 15);
         else if (img_hdr[6][2] && pick < 60)
            len = 16 + 512 + $urandom_range(0, 40);
         else
            len = 16 + $urandom_range(0, 40);
         send_image(len);
         sent += len;
      end
      req_tvalid <= 1'b0;

      // let the queue empty, then allow for anything still in flight
      @(negedge clock);
      while (results_waiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_waiting == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
